// File: rtl/cie_pkg.sv
// ----------------------------------------------------------------------------
// cie_pkg: shared types and constants of the instruction execute unit
// Opcodes, operation classes, queue word layout, memory requests, results.
// ----------------------------------------------------------------------------
package cie_pkg;

   // Program, stack and memory sizes.
   localparam int PROG_LINES  = 1024;
   localparam int IP_W        = 10;
   localparam int RA_W        = IP_W + 1;
   localparam int STACK_DEPTH = 16;
   localparam int SP_AW       = 4;
   localparam int SP_CW       = SP_AW + 1;
   localparam int MEM_BYTES   = 65536;
   localparam int MEM_AW      = 16;
   localparam int ROW_W       = MEM_AW - 1;
   localparam int MEM_ROWS    = MEM_BYTES / 2;
   localparam int PLEN_W      = 11;

   // Architectural constants.
   localparam logic [15:0] SP_RESET = 16'hFFFE;
   localparam logic [15:0] SIGN_BIT = 16'h8000;

   // Register indexes.
   localparam logic [2:0] REG_AX = 3'd0;
   localparam logic [2:0] REG_CX = 3'd2;
   localparam logic [2:0] REG_DX = 3'd3;
   localparam logic [2:0] REG_SP = 3'd4;

   // Flag bit positions.
   localparam int FB_Z = 0;
   localparam int FB_C = 1;
   localparam int FB_S = 2;
   localparam int FB_O = 3;
   localparam int FB_D = 4;

   // Error codes.
   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_DIV0  = 3'd1;
   localparam logic [2:0] ERR_LABEL = 3'd2;
   localparam logic [2:0] ERR_RET   = 3'd3;
   localparam logic [2:0] ERR_STACK = 3'd4;

   // Configuration register index.
   localparam logic REG_IDX_PLEN = 1'b0;

   typedef enum logic [4:0] {
      OP_MOV, OP_XCHG, OP_PUSH, OP_POP, OP_ADD, OP_SUB, OP_CMP, OP_INC,
      OP_DEC, OP_NEG, OP_MUL, OP_DIV, OP_LOAD, OP_STORE, OP_IN, OP_OUT,
      OP_POKE, OP_CLC, OP_STC, OP_CMC, OP_CLD, OP_STD, OP_NOP, OP_HLT,
      OP_JMP, OP_JE, OP_JNE, OP_JG, OP_JL, OP_CALL, OP_RET, OP_LOOP
   } mode_type;

   // Class chosen by the front end; it picks the back end's path.
   typedef enum logic [1:0] {
      CL_SIMPLE, CL_LOAD, CL_MUL, CL_DIV
   } class_type;

   typedef struct packed {
      mode_type    mode;
      logic [2:0]  dst_reg;
      logic [2:0]  src_reg;
      logic        src_is_imm;
      logic [15:0] imm;
      logic [9:0]  target;
      logic        target_found;
      logic [15:0] in_value;
      logic [7:0]  port;
      logic [15:0] poke_value;
      class_type   cls;
   } item_type;

   typedef struct packed {
      logic              rd;
      logic              wr_lo;
      logic              wr_hi;
      logic [MEM_AW-1:0] addr;
      logic [15:0]       wdata;
   } mem_req_type;

   typedef struct packed {
      logic [IP_W-1:0] next_ip;
      logic            halted;
      logic [2:0]      error;
      logic            out_valid;
      logic [7:0]      out_port;
      logic [15:0]     out_value;
      logic [4:0]      flags;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EXEC, ST_MEM, ST_MUL, ST_DIV, ST_FIN
   } exec_state_type;

   // Operation class of an opcode.
   function automatic class_type classify(input mode_type m);
      class_type c;
      case (m)
         OP_LOAD, OP_POP: c = CL_LOAD;
         OP_MUL:          c = CL_MUL;
         OP_DIV:          c = CL_DIV;
         default:         c = CL_SIMPLE;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/cie_front.sv
// ----------------------------------------------------------------------------
// cie_front: instruction intake and queue
// Accepts instruction words, tags each with its class and holds two in a queue.
// ----------------------------------------------------------------------------
module cie_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // dst_reg, src_reg, src_is_imm, imm, target, target_found, in_value,
   // port, poke_value from bit 0 up; zero filled to 80 bits
   input  logic [79:0]      req_tdata,
   // mode
   input  logic [4:0]       req_tuser,
   input  logic             pop,
   output logic             head_valid,
   output cie_pkg::item_type head
);
   import cie_pkg::*;

   item_type   items_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   word_in;
   logic       push;

   // Unpack the incoming word and classify it.
   always_comb begin
      word_in.mode         = mode_type'(req_tuser);
      word_in.dst_reg      = req_tdata[2:0];
      word_in.src_reg      = req_tdata[5:3];
      word_in.src_is_imm   = req_tdata[6];
      word_in.imm          = req_tdata[22:7];
      word_in.target       = req_tdata[32:23];
      word_in.target_found = req_tdata[33];
      word_in.in_value     = req_tdata[49:34];
      word_in.port         = req_tdata[57:50];
      word_in.poke_value   = req_tdata[73:58];
      word_in.cls          = classify(mode_type'(req_tuser));
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != 2'd0);
   assign head       = items_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         items_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule

// File: rtl/cie_mem.sv
// ----------------------------------------------------------------------------
// cie_mem: byte data memory
// Two byte banks (even and odd addresses) give one word access per cycle
// outside the clearing pass, which zeroes every row after reset.
// ----------------------------------------------------------------------------
module cie_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  cie_pkg::mem_req_type req,
   output logic [15:0]          rd_data,
   output logic                 busy
);
   import cie_pkg::*;

   logic [7:0]       even_mem [MEM_ROWS];
   logic [7:0]       odd_mem  [MEM_ROWS];
   logic [ROW_W-1:0] clr_ff, clr_in;
   logic             busy_ff, busy_in;
   logic [ROW_W-1:0] row_odd, row_even;
   logic [ROW_W-1:0] addr_even, addr_odd;
   logic             we_even, we_odd;
   logic [7:0]       d_even, d_odd;
   logic [7:0]       q_even_ff, q_odd_ff;
   logic             swap_ff;

   // The low byte sits at the given address, the high byte one above it.
   always_comb begin
      row_odd  = req.addr[MEM_AW-1:1];
      row_even = req.addr[0] ? row_odd + 1'b1 : row_odd;
      if (busy_ff) begin
         addr_even = clr_ff;
         addr_odd  = clr_ff;
         we_even   = 1'b1;
         we_odd    = 1'b1;
         d_even    = 8'd0;
         d_odd     = 8'd0;
      end else begin
         addr_even = row_even;
         addr_odd  = row_odd;
         we_even   = req.addr[0] ? req.wr_hi : req.wr_lo;
         we_odd    = req.addr[0] ? req.wr_lo : req.wr_hi;
         d_even    = req.addr[0] ? req.wdata[15:8] : req.wdata[7:0];
         d_odd     = req.addr[0] ? req.wdata[7:0] : req.wdata[15:8];
      end
   end

   // Clearing pass, one row of both banks per cycle.
   always_comb begin
      clr_in  = clr_ff + 1'b1;
      busy_in = busy_ff && (clr_ff != ROW_W'(MEM_ROWS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   // Even bank.
   always_ff @(posedge clock) begin
      if (we_even) begin
         even_mem[addr_even] <= d_even;
      end
      q_even_ff <= even_mem[addr_even];
   end

   // Odd bank.
   always_ff @(posedge clock) begin
      if (we_odd) begin
         odd_mem[addr_odd] <= d_odd;
      end
      q_odd_ff <= odd_mem[addr_odd];
   end

   always_ff @(posedge clock) begin
      swap_ff <= req.addr[0];
   end

   assign rd_data = swap_ff ? {q_even_ff, q_odd_ff} : {q_odd_ff, q_even_ff};
   assign busy    = busy_ff;

endmodule

// File: rtl/cie_div.sv
// ----------------------------------------------------------------------------
// cie_div: iterative unsigned divider
// Divides 32 bits by 16 bits, one quotient bit per cycle (restoring).
// ----------------------------------------------------------------------------
module cie_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [15:0] remainder
);
   import cie_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] dsr_ff;
   logic [16:0] trial;
   logic [16:0] diff;
   logic        ge;

   // One restoring step per cycle.
   always_comb begin
      trial   = {rem_ff, quo_ff[31]};
      diff    = trial - {1'b0, dsr_ff};
      ge      = (trial >= {1'b0, dsr_ff});
      rem_in  = ge ? diff[15:0] : trial[15:0];
      quo_in  = {quo_ff[30:0], ge};
      cnt_in  = cnt_ff + 1'b1;
      busy_in = busy_ff && (cnt_ff != 5'd31);
      done_in = busy_ff && (cnt_ff == 5'd31);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (busy_ff) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/cie_exec.sv
// ----------------------------------------------------------------------------
// cie_exec: instruction back end
// Sequencer that executes one queued instruction at a time against the
// register file, flags, line pointer, return stack and data memory.
// ----------------------------------------------------------------------------
module cie_exec (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  cie_pkg::item_type       head,
   output logic                    pop,
   input  logic                    slot_free,
   input  logic [cie_pkg::PLEN_W-1:0] program_length,
   output logic                    fin,
   output cie_pkg::rsp_type        result
);
   import cie_pkg::*;

   exec_state_type state_ff, state_in;

   logic [15:0]      rf_ff [8];
   logic [15:0]      rf_in [8];
   logic [4:0]       flags_ff, flags_in;
   logic [IP_W-1:0]  lp_ff, lp_in;
   logic [SP_CW-1:0] rc_ff, rc_in;
   logic [RA_W-1:0]  stack_ff [STACK_DEPTH];
   logic             stack_we;
   logic [RA_W-1:0]  stack_wd;

   item_type         cur_ff;
   logic [15:0]      a_ff, b_ff;
   logic [31:0]      prod_ff, prod_in;

   logic [RA_W-1:0]  pnext_ff, pnext_in;
   logic [2:0]       perr_ff, perr_in;
   logic             pstop_ff, pstop_in;
   logic             pov_ff, pov_in;
   logic [7:0]       pport_ff, pport_in;
   logic [15:0]      pval_ff, pval_in;

   mem_req_type      mreq;
   logic [15:0]      mem_rd;
   logic             mem_busy;
   logic             div_start;
   logic             div_done;
   logic [31:0]      div_q;
   logic [15:0]      div_r;

   logic [RA_W-1:0]  lp_plus1;
   logic [15:0]      src, sp, new_sp, push_src;
   logic [15:0]      sum, diff, res1, cx_dec;
   logic             stop;

   cie_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (mreq),
      .rd_data (mem_rd),
      .busy    (mem_busy)
   );

   cie_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  ({rf_ff[REG_DX], rf_ff[REG_AX]}),
      .divisor   (b_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid && slot_free && !mem_busy) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            case (cur_ff.cls)
               CL_LOAD: state_in = ST_MEM;
               CL_MUL:  state_in = ST_MUL;
               CL_DIV:  state_in = (b_ff == 16'd0) ? ST_FIN : ST_DIV;
               default: state_in = ST_FIN;
            endcase
         end
         ST_MEM: state_in = ST_FIN;
         ST_MUL: state_in = ST_FIN;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Shared values of the execute step.
   always_comb begin
      src      = b_ff;
      sp       = rf_ff[REG_SP];
      new_sp   = sp - 16'd2;
      push_src = (!cur_ff.src_is_imm && cur_ff.src_reg == REG_SP) ? new_sp : b_ff;
      sum      = a_ff + src;
      diff     = a_ff - src;
      cx_dec   = rf_ff[REG_CX] - 16'd1;
      lp_plus1 = {1'b0, lp_ff} + 1'b1;
      stop     = pstop_ff || (perr_ff != ERR_NONE) || (pnext_ff >= program_length)
                 || (pnext_ff >= RA_W'(PROG_LINES));
   end

   // Datapath and outputs of each state.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         rf_in[i] = rf_ff[i];
      end
      flags_in  = flags_ff;
      lp_in     = lp_ff;
      rc_in     = rc_ff;
      stack_we  = 1'b0;
      stack_wd  = lp_plus1;
      prod_in   = prod_ff;
      pnext_in  = pnext_ff;
      perr_in   = perr_ff;
      pstop_in  = pstop_ff;
      pov_in    = pov_ff;
      pport_in  = pport_ff;
      pval_in   = pval_ff;
      res1      = '0;
      mreq      = '0;
      div_start = 1'b0;
      pop       = 1'b0;
      fin       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            pop = head_valid && slot_free && !mem_busy;
         end

         ST_EXEC: begin
            pnext_in = lp_plus1;
            perr_in  = ERR_NONE;
            pstop_in = 1'b0;
            pov_in   = 1'b0;
            pport_in = '0;
            pval_in  = '0;
            case (cur_ff.mode)
               OP_MOV: rf_in[cur_ff.dst_reg] = src;
               OP_XCHG: begin
                  if (cur_ff.src_is_imm) begin
                     rf_in[cur_ff.dst_reg] = '0;
                  end else begin
                     rf_in[cur_ff.dst_reg] = b_ff;
                     rf_in[cur_ff.src_reg] = a_ff;
                  end
               end
               OP_PUSH: begin
                  rf_in[REG_SP] = new_sp;
                  mreq.wr_lo    = 1'b1;
                  mreq.wr_hi    = 1'b1;
                  mreq.addr     = new_sp[MEM_AW-1:0];
                  mreq.wdata    = push_src;
               end
               OP_POP: begin
                  mreq.rd       = 1'b1;
                  mreq.addr     = sp[MEM_AW-1:0];
                  rf_in[REG_SP] = sp + 16'd2;
               end
               OP_ADD: begin
                  rf_in[cur_ff.dst_reg] = sum;
                  flags_in[FB_Z] = (sum == 16'd0);
                  flags_in[FB_S] = sum[15];
                  flags_in[FB_O] = (a_ff[15] == src[15]) && (sum[15] != a_ff[15]);
                  flags_in[FB_C] = (sum < a_ff) || (sum < src);
               end
               OP_SUB, OP_CMP: begin
                  if (cur_ff.mode == OP_SUB) begin
                     rf_in[cur_ff.dst_reg] = diff;
                  end
                  flags_in[FB_Z] = (diff == 16'd0);
                  flags_in[FB_S] = diff[15];
                  flags_in[FB_O] = (a_ff[15] != src[15]) && (diff[15] != a_ff[15]);
                  flags_in[FB_C] = (a_ff < src);
               end
               OP_INC, OP_DEC, OP_NEG: begin
                  case (cur_ff.mode)
                     OP_INC:  res1 = a_ff + 16'd1;
                     OP_DEC:  res1 = a_ff - 16'd1;
                     default: res1 = 16'd0 - a_ff;
                  endcase
                  rf_in[cur_ff.dst_reg] = res1;
                  flags_in[FB_Z] = (res1 == 16'd0);
                  flags_in[FB_S] = res1[15];
                  if (cur_ff.mode == OP_NEG) begin
                     flags_in[FB_C] = (res1 != 16'd0);
                  end
               end
               OP_MUL: prod_in = rf_ff[REG_AX] * src;
               OP_DIV: begin
                  if (src == 16'd0) begin
                     perr_in = ERR_DIV0;
                  end else begin
                     div_start = 1'b1;
                  end
               end
               OP_LOAD: begin
                  mreq.rd   = 1'b1;
                  mreq.addr = src[MEM_AW-1:0];
               end
               OP_STORE: begin
                  mreq.wr_lo = 1'b1;
                  mreq.wr_hi = 1'b1;
                  mreq.addr  = src[MEM_AW-1:0];
                  mreq.wdata = a_ff;
               end
               OP_IN: rf_in[cur_ff.dst_reg] = cur_ff.in_value;
               OP_OUT: begin
                  pov_in   = 1'b1;
                  pport_in = cur_ff.port;
                  pval_in  = src;
               end
               OP_POKE: begin
                  mreq.wr_lo = 1'b1;
                  mreq.addr  = src[MEM_AW-1:0];
                  mreq.wdata = {8'd0, cur_ff.poke_value[7:0]};
               end
               OP_CLC: flags_in[FB_C] = 1'b0;
               OP_STC: flags_in[FB_C] = 1'b1;
               OP_CMC: flags_in[FB_C] = ~flags_ff[FB_C];
               OP_CLD: flags_in[FB_D] = 1'b0;
               OP_STD: flags_in[FB_D] = 1'b1;
               OP_NOP: ;
               OP_HLT: pstop_in = 1'b1;
               OP_JMP: begin
                  if (cur_ff.target_found) begin
                     pnext_in = {1'b0, cur_ff.target};
                  end else begin
                     perr_in = ERR_LABEL;
                  end
               end
               OP_JE: begin
                  if (flags_ff[FB_Z] && cur_ff.target_found) begin
                     pnext_in = {1'b0, cur_ff.target};
                  end
               end
               OP_JNE: begin
                  if (!flags_ff[FB_Z] && cur_ff.target_found) begin
                     pnext_in = {1'b0, cur_ff.target};
                  end
               end
               OP_JG: begin
                  if (!flags_ff[FB_Z] && (flags_ff[FB_S] == flags_ff[FB_O])
                      && cur_ff.target_found) begin
                     pnext_in = {1'b0, cur_ff.target};
                  end
               end
               OP_JL: begin
                  if ((flags_ff[FB_S] != flags_ff[FB_O]) && cur_ff.target_found) begin
                     pnext_in = {1'b0, cur_ff.target};
                  end
               end
               OP_CALL: begin
                  if (!cur_ff.target_found) begin
                     perr_in = ERR_LABEL;
                  end else if (rc_ff >= SP_CW'(STACK_DEPTH)) begin
                     perr_in = ERR_STACK;
                  end else begin
                     stack_we = 1'b1;
                     rc_in    = rc_ff + 1'b1;
                     pnext_in = {1'b0, cur_ff.target};
                  end
               end
               OP_RET: begin
                  if (rc_ff == '0 || rc_ff > SP_CW'(STACK_DEPTH)) begin
                     perr_in = ERR_RET;
                  end else begin
                     rc_in    = rc_ff - 1'b1;
                     pnext_in = stack_ff[rc_in[SP_AW-1:0]];
                  end
               end
               OP_LOOP: begin
                  rf_in[REG_CX] = cx_dec;
                  if (cx_dec != 16'd0 && cur_ff.target_found) begin
                     pnext_in = {1'b0, cur_ff.target};
                  end
               end
               default: ;
            endcase
         end

         // Loaded word lands after the stack pointer update.
         ST_MEM: rf_in[cur_ff.dst_reg] = mem_rd;

         ST_MUL: begin
            rf_in[REG_AX]  = prod_ff[15:0];
            rf_in[REG_DX]  = prod_ff[31:16];
            flags_in[FB_Z] = (prod_ff[15:0] == 16'd0);
            flags_in[FB_S] = prod_ff[15];
            flags_in[FB_C] = (prod_ff[31:16] != 16'd0);
         end

         ST_DIV: begin
            if (div_done) begin
               rf_in[REG_AX] = div_q[15:0];
               rf_in[REG_DX] = div_r;
            end
         end

         ST_FIN: begin
            fin   = 1'b1;
            lp_in = stop ? '0 : pnext_ff[IP_W-1:0];
         end

         default: ;
      endcase
   end

   // Result word of the finished instruction.
   always_comb begin
      result.next_ip   = lp_in;
      result.halted    = stop;
      result.error     = perr_ff;
      result.out_valid = pov_ff;
      result.out_port  = pport_ff;
      result.out_value = pval_ff;
      result.flags     = flags_ff;
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 8; i++) begin
            rf_ff[i] <= '0;
         end
         rf_ff[REG_SP] <= SP_RESET;
         flags_ff <= '0;
         lp_ff    <= '0;
         rc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         for (int i = 0; i < 8; i++) begin
            rf_ff[i] <= rf_in[i];
         end
         flags_ff <= flags_in;
         lp_ff    <= lp_in;
         rc_ff    <= rc_in;
      end
   end

   // Return stack entries.
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_ff[rc_ff[SP_AW-1:0]] <= stack_wd;
      end
   end

   // Operand and pending result registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
      if (state_ff == ST_READ) begin
         a_ff <= rf_ff[cur_ff.dst_reg];
         b_ff <= cur_ff.src_is_imm ? cur_ff.imm : rf_ff[cur_ff.src_reg];
      end
      prod_ff  <= prod_in;
      pnext_ff <= pnext_in;
      perr_ff  <= perr_in;
      pstop_ff <= pstop_in;
      pov_ff   <= pov_in;
      pport_ff <= pport_in;
      pval_ff  <= pval_in;
   end

endmodule

// File: rtl/cpu16_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// cpu16_instruction_execute_unit: 16-bit instruction execute unit
// Each instruction passes through the read, execute and finish states; LOAD,
// POP and MUL add a memory or multiply state, DIV by a nonzero divisor waits
// on the divider (one quotient bit per cycle). The next one is taken once
// the last is done. Reset: synchronous; a clearing pass zeroes the data
// memory before the first instruction executes; words are queued meanwhile.
// ----------------------------------------------------------------------------
module cpu16_instruction_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // dst_reg, src_reg, src_is_imm, imm, target, target_found, in_value,
   // port, poke_value from bit 0 up; zero filled to 80 bits
   input  logic [79:0] req_tdata,
   // mode
   input  logic [4:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_ip, halted, error, out_valid, out_port, out_value, flags from
   // bit 0 up; zero filled to 48 bits
   output logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cie_pkg::*;

   logic [PLEN_W-1:0] plen_ff;
   item_type          head;
   logic              head_valid;
   logic              pop;
   logic              fin;
   rsp_type           result;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_IDX_PLEN) ? {21'd0, plen_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_IDX_PLEN) begin
         plen_ff <= csr_pwdata[PLEN_W-1:0];
      end
   end

   cie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // The output slot counts as free while its word is being taken.
   cie_exec u_exec (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .slot_free      (!rsp_valid_ff || rsp_tready),
      .program_length (plen_ff),
      .fin            (fin),
      .result         (result)
   );

   // Output register.
   assign rsp_valid_in = fin || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.flags, rsp_ff.out_value, rsp_ff.out_port,
                        rsp_ff.out_valid, rsp_ff.error, rsp_ff.halted, rsp_ff.next_ip};

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the 16-bit instruction execute unit
// Instruction words go in on the req_ stream and one status word per
// instruction comes back on the rsp_ stream. A behavioral model of the
// machine state predicts every status word. A short directed table is run
// first, then random programs under several program lengths.
// ----------------------------------------------------------------------------
module tb;
   import cie_pkg::*;

   // One decoded instruction as the testbench sees it.
   typedef struct {
      mode_type    mode;
      logic [2:0]  dst_reg;
      logic [2:0]  src_reg;
      logic        src_is_imm;
      logic [15:0] imm;
      logic [9:0]  target;
      logic        target_found;
      logic [15:0] in_value;
      logic [7:0]  port;
      logic [15:0] poke_value;
   } instr_type;

   // Directed table row; a typed status word overrides the prediction.
   typedef struct {
      instr_type ins;
      bit        typed;
      rsp_type   want;
   } dir_row_type;

   localparam logic [2:0] ADDR_PLEN = {REG_IDX_PLEN, 2'b00};
   localparam int         WATCHDOG_LIMIT = 150000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic [4:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Model of the machine state.
   logic [15:0] m_regs [8];
   logic [4:0]  m_flags;
   int          m_ip;
   int          m_ret_stack [STACK_DEPTH];
   int          m_ret_count;
   logic [7:0]  m_mem [MEM_BYTES];
   int          m_plen;

   rsp_type     status_q [$];
   dir_row_type dir_table [$];
   int          error_count;
   int          send_idle;
   int          recv_idle;
   int          quiet_cycles;

   cpu16_instruction_execute_unit u_dut (.*);

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Reads a little-endian word from the model memory.
   function automatic logic [15:0] mem_word(input logic [15:0] addr);
      return {m_mem[16'(addr + 16'd1)], m_mem[addr]};
   endfunction

   // Executes one instruction on the model and returns its status word.
   function automatic rsp_type execute_instr(input instr_type x);
      rsp_type     s;
      logic [15:0] src;
      logic [15:0] a;
      logic [15:0] r;
      logic [31:0] w;
      int          nxt;
      logic [2:0]  err;
      bit          stop;
      s   = '0;
      nxt = m_ip + 1;
      err = ERR_NONE;
      stop = 0;
      src = x.src_is_imm ? x.imm : m_regs[x.src_reg];
      a   = m_regs[x.dst_reg];
      case (x.mode)
         OP_MOV: m_regs[x.dst_reg] = src;
         OP_XCHG: begin
            if (x.src_is_imm) begin
               m_regs[x.dst_reg] = 16'd0;
            end else begin
               m_regs[x.dst_reg] = m_regs[x.src_reg];
               m_regs[x.src_reg] = a;
            end
         end
         OP_PUSH: begin
            m_regs[REG_SP] = m_regs[REG_SP] - 16'd2;
            src = x.src_is_imm ? x.imm : m_regs[x.src_reg];
            m_mem[m_regs[REG_SP]] = src[7:0];
            m_mem[16'(m_regs[REG_SP] + 16'd1)] = src[15:8];
         end
         OP_POP: begin
            r = mem_word(m_regs[REG_SP]);
            m_regs[REG_SP] = m_regs[REG_SP] + 16'd2;
            m_regs[x.dst_reg] = r;
         end
         OP_ADD: begin
            r = a + src;
            m_regs[x.dst_reg] = r;
            m_flags[FB_Z] = (r == 16'd0);
            m_flags[FB_S] = r[15];
            m_flags[FB_O] = (a[15] == src[15]) && (r[15] != a[15]);
            m_flags[FB_C] = (r < a) || (r < src);
         end
         OP_SUB, OP_CMP: begin
            r = a - src;
            if (x.mode == OP_SUB) m_regs[x.dst_reg] = r;
            m_flags[FB_Z] = (r == 16'd0);
            m_flags[FB_S] = r[15];
            m_flags[FB_O] = (a[15] != src[15]) && (r[15] != a[15]);
            m_flags[FB_C] = a < src;
         end
         OP_INC, OP_DEC, OP_NEG: begin
            r = (x.mode == OP_INC) ? a + 16'd1 : (x.mode == OP_DEC) ? a - 16'd1 : -a;
            m_regs[x.dst_reg] = r;
            m_flags[FB_Z] = (r == 16'd0);
            m_flags[FB_S] = r[15];
            if (x.mode == OP_NEG) m_flags[FB_C] = (r != 16'd0);
         end
         OP_MUL: begin
            w = m_regs[REG_AX] * src;
            m_regs[REG_AX] = w[15:0];
            m_regs[REG_DX] = w[31:16];
            m_flags[FB_Z] = (w[15:0] == 16'd0);
            m_flags[FB_S] = w[15];
            m_flags[FB_C] = (w[31:16] != 16'd0);
         end
         OP_DIV: begin
            if (src == 16'd0) begin
               err = ERR_DIV0;
            end else begin
               w = {m_regs[REG_DX], m_regs[REG_AX]};
               m_regs[REG_AX] = 16'(w / src);
               m_regs[REG_DX] = 16'(w % src);
            end
         end
         OP_LOAD: m_regs[x.dst_reg] = mem_word(src);
         OP_STORE: begin
            m_mem[src] = a[7:0];
            m_mem[16'(src + 16'd1)] = a[15:8];
         end
         OP_IN: m_regs[x.dst_reg] = x.in_value;
         OP_OUT: begin
            s.out_valid = 1'b1;
            s.out_port  = x.port;
            s.out_value = src;
         end
         OP_POKE: m_mem[src] = x.poke_value[7:0];
         OP_CLC: m_flags[FB_C] = 1'b0;
         OP_STC: m_flags[FB_C] = 1'b1;
         OP_CMC: m_flags[FB_C] = ~m_flags[FB_C];
         OP_CLD: m_flags[FB_D] = 1'b0;
         OP_STD: m_flags[FB_D] = 1'b1;
         OP_NOP: ;
         OP_HLT: stop = 1;
         OP_JMP: if (x.target_found) nxt = x.target; else err = ERR_LABEL;
         OP_JE: if (m_flags[FB_Z] && x.target_found) nxt = x.target;
         OP_JNE: if (!m_flags[FB_Z] && x.target_found) nxt = x.target;
         OP_JG: begin
            if (!m_flags[FB_Z] && m_flags[FB_S] == m_flags[FB_O] && x.target_found)
               nxt = x.target;
         end
         OP_JL: if (m_flags[FB_S] != m_flags[FB_O] && x.target_found) nxt = x.target;
         OP_CALL: begin
            if (!x.target_found) begin
               err = ERR_LABEL;
            end else if (m_ret_count >= STACK_DEPTH) begin
               err = ERR_STACK;
            end else begin
               m_ret_stack[m_ret_count] = nxt;
               m_ret_count++;
               nxt = x.target;
            end
         end
         OP_RET: begin
            if (m_ret_count == 0) begin
               err = ERR_RET;
            end else begin
               m_ret_count--;
               nxt = m_ret_stack[m_ret_count];
            end
         end
         default: begin
            // LOOP always counts CX down, then branches if it is nonzero and the label exists.
            m_regs[REG_CX] = m_regs[REG_CX] - 16'd1;
            if (m_regs[REG_CX] != 16'd0 && x.target_found) nxt = x.target;
         end
      endcase
      if (err != ERR_NONE) stop = 1;
      if (!stop && (nxt >= m_plen || nxt >= PROG_LINES)) stop = 1;
      m_ip = stop ? 0 : nxt;
      s.next_ip = m_ip[9:0];
      s.halted  = stop;
      s.error   = err;
      s.flags   = m_flags;
      return s;
   endfunction

   function automatic instr_type make_instr(input mode_type m, input logic [2:0] d,
                                            input logic [2:0] sr, input logic isimm,
                                            input logic [15:0] imm, input logic [9:0] tgt,
                                            input logic found);
      instr_type x;
      x = '{m, d, sr, isimm, imm, tgt, found, 16'hFFFF, 8'hFF, 16'h5AA5};
      return x;
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(input instr_type ins, input bit typed,
                                   input rsp_type want);
      dir_row_type row;
      row.ins   = ins;
      row.typed = typed;
      row.want  = want;
      dir_table.insert(dir_table.size(), row);
   endfunction

   // Random instruction; labels mostly exist and targets mostly stay in the program.
   function automatic instr_type rand_instr();
      instr_type x;
      x.mode         = mode_type'($urandom_range(31));
      x.dst_reg      = 3'($urandom);
      x.src_reg      = 3'($urandom);
      x.src_is_imm   = 1'($urandom);
      x.imm          = ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom);
      x.target       = (m_plen > 1 && $urandom_range(9) != 0) ?
                       10'($urandom_range(m_plen - 1)) : 10'($urandom);
      x.target_found = ($urandom_range(99) < 88);
      x.in_value     = 16'($urandom);
      x.port         = 8'($urandom);
      x.poke_value   = 16'($urandom);
      return x;
   endfunction

   // Sends one instruction word and records its expected status word.
   task automatic send_instr(input instr_type x, input bit typed, input rsp_type want);
      rsp_type p;
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= x.mode;
      req_tdata  <= {6'd0, x.poke_value, x.port, x.in_value, x.target_found, x.target,
                     x.imm, x.src_is_imm, x.src_reg, x.dst_reg};
      do @(posedge clock); while (!req_tready);
      p = execute_instr(x);
      status_q.insert(status_q.size(), typed ? want : p);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_instr(rand_instr(), 0, '0);
      req_tvalid <= 1'b0;
   endtask

   // Waits until every status word has arrived, plus the longest latency.
   task automatic drain();
      while (status_q.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_plen(input int value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ADDR_PLEN;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      m_plen = value;
   endtask

   function automatic rsp_type typed_status(input int ip, input logic halt,
                                            input logic [2:0] err, input logic [4:0] fl);
      rsp_type s;
      s = '0;
      s.next_ip = 10'(ip);
      s.halted  = halt;
      s.error   = err;
      s.flags   = fl;
      return s;
   endfunction

   // Status word checker and receiver back-pressure.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[9:0], rsp_tdata[10], rsp_tdata[13:11], rsp_tdata[14],
                 rsp_tdata[22:15], rsp_tdata[38:23], rsp_tdata[43:39]};
         if (status_q.size() == 0) begin
            $error("status word with none expected: %h", rsp_tdata);
            error_count++;
         end else begin
            want = status_q.pop_front();
            if (got.next_ip != want.next_ip) begin
               $error("next_ip expected %0d actual %0d", want.next_ip, got.next_ip);
               error_count++;
            end
            if (got.halted != want.halted) begin
               $error("halted expected %0d actual %0d", want.halted, got.halted);
               error_count++;
            end
            if (got.error != want.error) begin
               $error("error expected %0d actual %0d", want.error, got.error);
               error_count++;
            end
            if (got.out_valid != want.out_valid) begin
               $error("out_valid expected %0d actual %0d", want.out_valid, got.out_valid);
               error_count++;
            end
            if (got.out_port != want.out_port) begin
               $error("out_port expected %0d actual %0d", want.out_port, got.out_port);
               error_count++;
            end
            if (got.out_value != want.out_value) begin
               $error("out_value expected %h actual %h", want.out_value, got.out_value);
               error_count++;
            end
            if (got.flags != want.flags) begin
               $error("flags expected %b actual %b", want.flags, got.flags);
               error_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // Watchdog on cycles with no word moving on either stream.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus.
   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = OP_NOP;
      rsp_tready   = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      error_count  = 0;
      quiet_cycles = 0;
      send_idle    = 23;
      recv_idle    = 51;
      m_regs       = '{default: 16'd0};
      m_regs[REG_SP] = SP_RESET;
      m_flags      = '0;
      m_ip         = 0;
      m_ret_count  = 0;
      m_ret_stack  = '{default: 0};
      m_mem        = '{default: 8'd0};
      m_plen       = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_plen(PROG_LINES);

      // Directed table: extremes, each operation class, and the division, label and return errors.
      add_row(make_instr(OP_MOV, REG_AX, 0, 1, 16'hFFFF, 0, 1), 1,
              typed_status(1, 0, ERR_NONE, 5'b00000));
      add_row(make_instr(OP_ADD, REG_AX, 0, 1, 16'h0001, 0, 1), 1,
              typed_status(2, 0, ERR_NONE, 5'b00011));
      add_row(make_instr(OP_DIV, REG_AX, 0, 1, 16'h0000, 0, 1), 1,
              typed_status(0, 1, ERR_DIV0, 5'b00011));
      add_row(make_instr(OP_JMP, 0, 0, 0, 0, 10'd5, 0), 1,
              typed_status(0, 1, ERR_LABEL, 5'b00011));
      add_row(make_instr(OP_RET, 0, 0, 0, 0, 0, 1), 1,
              typed_status(0, 1, ERR_RET, 5'b00011));
      add_row(make_instr(OP_MOV, REG_DX, 0, 1, 16'hFFFF, 0, 1), 0, '0);
      add_row(make_instr(OP_MOV, REG_AX, 0, 1, SIGN_BIT, 0, 1), 0, '0);
      add_row(make_instr(OP_SUB, REG_AX, 0, 1, 16'h0001, 0, 1), 0, '0);
      add_row(make_instr(OP_CMP, REG_AX, REG_DX, 0, 0, 0, 1), 0, '0);
      add_row(make_instr(OP_NEG, REG_AX, 0, 0, 0, 0, 1), 0, '0);
      add_row(make_instr(OP_MUL, 0, 0, 1, 16'hFFFF, 0, 1), 0, '0);
      add_row(make_instr(OP_DIV, 0, 0, 1, 16'h0003, 0, 1), 0, '0);
      add_row(make_instr(OP_PUSH, 0, REG_SP, 0, 0, 0, 1), 0, '0);
      add_row(make_instr(OP_POP, 3'd1, 0, 0, 0, 0, 1), 0, '0);
      add_row(make_instr(OP_XCHG, REG_AX, 3'd1, 0, 0, 0, 1), 0, '0);
      add_row(make_instr(OP_XCHG, REG_CX, 0, 1, 16'h1234, 0, 1), 0, '0);
      add_row(make_instr(OP_STORE, REG_DX, 0, 1, 16'hFFFF, 0, 1), 0, '0);
      add_row(make_instr(OP_LOAD, 3'd6, 0, 1, 16'hFFFF, 0, 1), 0, '0);
      add_row(make_instr(OP_IN, 3'd7, 0, 0, 0, 0, 1), 0, '0);
      add_row(make_instr(OP_OUT, 0, REG_AX, 0, 0, 0, 1), 0, '0);
      add_row(make_instr(OP_POKE, 0, 0, 1, 16'h0000, 0, 1), 0, '0);
      add_row(make_instr(OP_STD, 0, 0, 0, 0, 0, 1), 0, '0);
      add_row(make_instr(OP_CALL, 0, 0, 0, 0, 10'd1023, 1), 0, '0);
      add_row(make_instr(OP_RET, 0, 0, 0, 0, 0, 1), 0, '0);
      add_row(make_instr(OP_LOOP, 0, 0, 0, 0, 10'd7, 1), 0, '0);
      add_row(make_instr(OP_HLT, 0, 0, 0, 0, 0, 1), 0, '0);
      foreach (dir_table[i]) send_instr(dir_table[i].ins, dir_table[i].typed, dir_table[i].want);
      send_random(180);

      // Short program: the end of the program is reached often.
      drain();
      send_idle = 51;
      recv_idle = 23;
      write_plen(20);
      send_random(120);

      // Empty program: every instruction halts.
      drain();
      write_plen(0);
      send_random(30);

      // Nested calls overflow the return stack, then unwind past empty.
      drain();
      send_idle = 0;
      recv_idle = 0;
      write_plen(PROG_LINES);
      repeat (STACK_DEPTH + 2)
         send_instr(make_instr(OP_CALL, 0, 0, 0, 0, 10'($urandom_range(1022)), 1), 0, '0);
      repeat (STACK_DEPTH + 2) send_instr(make_instr(OP_RET, 0, 0, 0, 0, 0, 1), 0, '0);
      send_random(150);

      drain();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
